// File: rtl/core/pgs_pkg.sv
`timescale 1ns / 1ps

package pgs_pkg;

  // Fixed field widths
  localparam int unsigned COORD_W   = 32;
  localparam int unsigned SUM_W     = 53;
  localparam int unsigned GW_W      = 11;
  localparam int unsigned CNT_OUT_W = 21;

  // Register and frame defaults
  localparam logic [GW_W-1:0]           GW_RESET = 11'd640;
  localparam logic signed [COORD_W-1:0] POS_MOST = 32'sh7FFF_FFFF;
  localparam logic signed [COORD_W-1:0] NEG_MOST = 32'sh8000_0000;

  // Operand source of the shared divider
  typedef enum logic [1:0] {
    DIV_SRC_X   = 2'd0,
    DIV_SRC_Y   = 2'd1,
    DIV_SRC_COL = 2'd2
  } div_src_e;

  // Controller to datapath commands
  typedef struct packed {
    logic     take;
    logic     exec;
    logic     div_load;
    div_src_e div_src;
    logic     div_step;
    logic     mean_x_store;
    logic     col_store;
    logic     result_load;
  } pgs_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic item_last;
  } pgs_status_t;

endpackage

// File: rtl/core/pgs_ram.sv
`timescale 1ns / 1ps

module pgs_ram #(
  parameter int unsigned WIDTH = 33,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write one port, read the other into a register
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/pgs_ctrl.sv
`timescale 1ns / 1ps

module pgs_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  input  logic                cfg_we_i,
  input  pgs_pkg::pgs_status_t status_i,
  output pgs_pkg::pgs_cmd_t    cmd_o
);

  localparam int unsigned DIV_STEPS = pgs_pkg::SUM_W;
  localparam int unsigned CNT_W     = $clog2(DIV_STEPS);
  localparam logic [CNT_W-1:0] STEP_LAST = CNT_W'(DIV_STEPS - 1);

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_EXEC   = 9'b000000010,
    ST_REMAP  = 9'b000000100,
    ST_COLSET = 9'b000001000,
    ST_DRAIN  = 9'b000010000,
    ST_DIVX   = 9'b000100000,
    ST_MEANX  = 9'b001000000,
    ST_DIVY   = 9'b010000000,
    ST_FINISH = 9'b100000000
  } state_e;

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               dirty_q, dirty_d;
  logic               out_valid_q, out_valid_d;

  // Sequence items, column recomputation and the two mean divisions
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    dirty_d     = dirty_q | cfg_we_i;
    out_valid_d = out_valid_q & out_stall_i;
    in_stall_o  = 1'b1;
    cmd_o       = '0;
    cmd_o.div_src = pgs_pkg::DIV_SRC_X;

    unique case (state_q)
      ST_IDLE: begin
        if (dirty_q && !cfg_we_i) begin
          cmd_o.div_load = 1'b1;
          cmd_o.div_src  = pgs_pkg::DIV_SRC_COL;
          dirty_d        = 1'b0;
          cnt_d          = '0;
          state_d        = ST_REMAP;
        end else if (!dirty_q && !cfg_we_i) begin
          in_stall_o = 1'b0;
          if (in_valid_i) begin
            cmd_o.take = 1'b1;
            state_d    = ST_EXEC;
          end
        end
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = status_i.item_last ? ST_DRAIN : ST_IDLE;
      end
      ST_REMAP: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == STEP_LAST) begin
          state_d = ST_COLSET;
        end
      end
      ST_COLSET: begin
        cmd_o.col_store = 1'b1;
        state_d         = ST_IDLE;
      end
      ST_DRAIN: begin
        // wait for the previous result transfer
        if (!out_valid_q) begin
          cmd_o.div_load = 1'b1;
          cmd_o.div_src  = pgs_pkg::DIV_SRC_X;
          cnt_d          = '0;
          state_d        = ST_DIVX;
        end
      end
      ST_DIVX: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == STEP_LAST) begin
          state_d = ST_MEANX;
        end
      end
      ST_MEANX: begin
        cmd_o.mean_x_store = 1'b1;
        cmd_o.div_load     = 1'b1;
        cmd_o.div_src      = pgs_pkg::DIV_SRC_Y;
        cnt_d              = '0;
        state_d            = ST_DIVY;
      end
      ST_DIVY: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == STEP_LAST) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        cmd_o.result_load = 1'b1;
        out_valid_d       = 1'b1;
        state_d           = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      dirty_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      dirty_q     <= dirty_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: rtl/core/pgs_dpath.sv
`timescale 1ns / 1ps

module pgs_dpath #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_POINTS = 1048576
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  pgs_pkg::pgs_cmd_t                      cmd_i,
  output pgs_pkg::pgs_status_t                   status_o,
  input  logic                                   cfg_we_i,
  input  logic [pgs_pkg::GW_W-1:0]               cfg_wdata_i,
  input  logic                                   point_valid_i,
  input  logic signed [pgs_pkg::COORD_W-1:0]     coord_x_i,
  input  logic signed [pgs_pkg::COORD_W-1:0]     coord_y_i,
  input  logic signed [pgs_pkg::COORD_W-1:0]     coord_z_i,
  input  logic                                   last_point_i,
  output logic [pgs_pkg::CNT_OUT_W-1:0]          valid_count_o,
  output logic signed [pgs_pkg::COORD_W-1:0]     min_x_o,
  output logic signed [pgs_pkg::COORD_W-1:0]     max_x_o,
  output logic signed [pgs_pkg::COORD_W-1:0]     min_y_o,
  output logic signed [pgs_pkg::COORD_W-1:0]     max_y_o,
  output logic signed [pgs_pkg::COORD_W-1:0]     min_z_o,
  output logic signed [pgs_pkg::COORD_W-1:0]     max_z_o,
  output logic [pgs_pkg::COORD_W-1:0]            mean_step_x_o,
  output logic [pgs_pkg::COORD_W-1:0]            mean_step_y_o
);

  localparam int unsigned CRD  = pgs_pkg::COORD_W;
  localparam int unsigned SW   = pgs_pkg::SUM_W;
  localparam int unsigned CW   = $clog2(MAX_WIDTH);
  localparam int unsigned WW   = $clog2(MAX_WIDTH + 1);
  localparam int unsigned NW   = $clog2(MAX_POINTS + 1);
  localparam int unsigned DVW  = (NW > WW) ? NW : WW;
  localparam int unsigned RW   = CRD + 1;
  localparam logic [NW-1:0] PTS_MAX = NW'(MAX_POINTS);
  localparam logic [WW-1:0] WID_MAX = WW'(MAX_WIDTH);

  function automatic logic [NW-1:0] sat_inc(input logic [NW-1:0] c);
    return (c == PTS_MAX) ? c : c + 1'b1;
  endfunction

  function automatic logic [SW-1:0] sat_add(input logic [SW-1:0] s, input logic [CRD-1:0] d);
    logic [SW:0] r;
    r = {1'b0, s} + (SW + 1)'(d);
    return r[SW] ? {SW{1'b1}} : r[SW-1:0];
  endfunction

  function automatic logic [CRD-1:0] abs_diff(input logic [CRD-1:0] a, input logic [CRD-1:0] b);
    logic [CRD:0] d;
    logic [CRD:0] m;
    d = {a[CRD-1], a} - {b[CRD-1], b};
    m = d[CRD] ? ((CRD + 1)'(0) - d) : d;
    return m[CRD-1:0];
  endfunction

  // Grid width register and its clamped value
  logic [pgs_pkg::GW_W-1:0] gw_q;
  logic [WW-1:0]            w_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gw_q <= pgs_pkg::GW_RESET;
    end else if (cfg_we_i) begin
      gw_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    if (gw_q == '0) begin
      w_eff = WW'(1);
    end else if (32'(gw_q) > 32'(MAX_WIDTH)) begin
      w_eff = WID_MAX;
    end else begin
      w_eff = WW'(gw_q);
    end
  end

  // Hold the accepted item
  logic                   it_valid_q, it_last_q;
  logic signed [CRD-1:0]  it_x_q, it_y_q, it_z_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      it_valid_q <= point_valid_i;
      it_x_q     <= coord_x_i;
      it_y_q     <= coord_y_i;
      it_z_q     <= coord_z_i;
      it_last_q  <= last_point_i;
    end
  end

  assign status_o.item_last = it_last_q;

  // Frame state
  logic signed [CRD-1:0] min_x_q, max_x_q, min_y_q, max_y_q, min_z_q, max_z_q;
  logic signed [CRD-1:0] min_x_d, max_x_d, min_y_d, max_y_d, min_z_d, max_z_d;
  logic [NW-1:0]         count_q, count_d, pairs_x_q, pairs_x_d, pairs_y_q, pairs_y_d;
  logic [NW-1:0]         items_q, items_d;
  logic [SW-1:0]         sum_x_q, sum_x_d, sum_y_q, sum_y_d;
  logic                  prior_valid_q, prior_valid_d;
  logic signed [CRD-1:0] prior_x_q, prior_x_d;
  logic [CW-1:0]         col_q, col_d;
  logic [31:0]           col_inc;
  logic                  items_ge_w;

  // Line buffer of the row above: valid bit and Y
  logic [RW-1:0]         row_rd;
  logic                  row_vld;
  logic [CRD-1:0]        row_y;

  pgs_ram #(
    .WIDTH (RW),
    .DEPTH (MAX_WIDTH)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.exec),
    .waddr_i (col_q),
    .wdata_i ({it_valid_q, it_y_q}),
    .raddr_i (col_q),
    .rdata_o (row_rd)
  );

  assign row_vld    = row_rd[CRD];
  assign row_y      = row_rd[CRD-1:0];
  assign items_ge_w = 32'(items_q) >= 32'(w_eff);
  assign col_inc    = 32'(col_q) + 32'd1;

  // Shared restoring divider
  logic [SW-1:0]  dv_quo_q;
  logic [DVW-1:0] dv_rem_q, dv_div_q;
  logic [DVW:0]   dv_trial, dv_diff;
  logic           dv_ge;
  logic [CRD-1:0] mean_now, mean_x_q;

  assign dv_trial = {dv_rem_q, dv_quo_q[SW-1]};
  assign dv_diff  = dv_trial - {1'b0, dv_div_q};
  assign dv_ge    = dv_trial >= {1'b0, dv_div_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_load) begin
      dv_rem_q <= '0;
      unique case (cmd_i.div_src)
        pgs_pkg::DIV_SRC_X: begin
          dv_quo_q <= sum_x_q;
          dv_div_q <= DVW'(pairs_x_q);
        end
        pgs_pkg::DIV_SRC_Y: begin
          dv_quo_q <= sum_y_q;
          dv_div_q <= DVW'(pairs_y_q);
        end
        pgs_pkg::DIV_SRC_COL: begin
          dv_quo_q <= SW'(items_q);
          dv_div_q <= DVW'(w_eff);
        end
        default: begin
          dv_quo_q <= '0;
          dv_div_q <= '0;
        end
      endcase
    end else if (cmd_i.div_step) begin
      dv_rem_q <= dv_ge ? dv_diff[DVW-1:0] : dv_trial[DVW-1:0];
      dv_quo_q <= {dv_quo_q[SW-2:0], dv_ge};
    end
  end

  // Zero with no pairs, clip quotients above 32 bits
  always_comb begin
    if (dv_div_q == '0) begin
      mean_now = '0;
    end else if (|dv_quo_q[SW-1:CRD]) begin
      mean_now = '1;
    end else begin
      mean_now = dv_quo_q[CRD-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mean_x_store) begin
      mean_x_q <= mean_now;
    end
  end

  // Update the frame state for one item, load the remapped column, clear per frame
  always_comb begin
    min_x_d = min_x_q; max_x_d = max_x_q;
    min_y_d = min_y_q; max_y_d = max_y_q;
    min_z_d = min_z_q; max_z_d = max_z_q;
    count_d       = count_q;
    pairs_x_d     = pairs_x_q;
    pairs_y_d     = pairs_y_q;
    sum_x_d       = sum_x_q;
    sum_y_d       = sum_y_q;
    items_d       = items_q;
    prior_valid_d = prior_valid_q;
    prior_x_d     = prior_x_q;
    col_d         = col_q;

    if (cmd_i.exec) begin
      if (it_valid_q) begin
        count_d = sat_inc(count_q);
        if (it_x_q < min_x_q) min_x_d = it_x_q;
        if (it_x_q > max_x_q) max_x_d = it_x_q;
        if (it_y_q < min_y_q) min_y_d = it_y_q;
        if (it_y_q > max_y_q) max_y_d = it_y_q;
        if (it_z_q < min_z_q) min_z_d = it_z_q;
        if (it_z_q > max_z_q) max_z_d = it_z_q;
        if (prior_valid_q) begin
          sum_x_d   = sat_add(sum_x_q, abs_diff(it_x_q, prior_x_q));
          pairs_x_d = sat_inc(pairs_x_q);
        end
        if (items_ge_w && row_vld) begin
          sum_y_d   = sat_add(sum_y_q, abs_diff(it_y_q, row_y));
          pairs_y_d = sat_inc(pairs_y_q);
        end
      end
      prior_valid_d = it_valid_q;
      prior_x_d     = it_x_q;
      items_d       = sat_inc(items_q);
      // the column freezes once the position counter saturates
      if (items_q != PTS_MAX) begin
        col_d = (col_inc == 32'(w_eff)) ? '0 : CW'(col_inc);
      end
    end

    if (cmd_i.col_store) begin
      col_d = dv_rem_q[CW-1:0];
    end

    if (cmd_i.result_load) begin
      min_x_d = pgs_pkg::POS_MOST; max_x_d = pgs_pkg::NEG_MOST;
      min_y_d = pgs_pkg::POS_MOST; max_y_d = pgs_pkg::NEG_MOST;
      min_z_d = pgs_pkg::POS_MOST; max_z_d = pgs_pkg::NEG_MOST;
      count_d       = '0;
      pairs_x_d     = '0;
      pairs_y_d     = '0;
      sum_x_d       = '0;
      sum_y_d       = '0;
      items_d       = '0;
      prior_valid_d = 1'b0;
      prior_x_d     = '0;
      col_d         = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_x_q <= pgs_pkg::POS_MOST; max_x_q <= pgs_pkg::NEG_MOST;
      min_y_q <= pgs_pkg::POS_MOST; max_y_q <= pgs_pkg::NEG_MOST;
      min_z_q <= pgs_pkg::POS_MOST; max_z_q <= pgs_pkg::NEG_MOST;
      count_q       <= '0;
      pairs_x_q     <= '0;
      pairs_y_q     <= '0;
      sum_x_q       <= '0;
      sum_y_q       <= '0;
      items_q       <= '0;
      prior_valid_q <= 1'b0;
      prior_x_q     <= '0;
      col_q         <= '0;
    end else begin
      min_x_q <= min_x_d; max_x_q <= max_x_d;
      min_y_q <= min_y_d; max_y_q <= max_y_d;
      min_z_q <= min_z_d; max_z_q <= max_z_d;
      count_q       <= count_d;
      pairs_x_q     <= pairs_x_d;
      pairs_y_q     <= pairs_y_d;
      sum_x_q       <= sum_x_d;
      sum_y_q       <= sum_y_d;
      items_q       <= items_d;
      prior_valid_q <= prior_valid_d;
      prior_x_q     <= prior_x_d;
      col_q         <= col_d;
    end
  end

  // Load the result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.result_load) begin
      valid_count_o <= pgs_pkg::CNT_OUT_W'(count_q);
      min_x_o       <= min_x_q;
      max_x_o       <= max_x_q;
      min_y_o       <= min_y_q;
      max_y_o       <= max_y_q;
      min_z_o       <= min_z_q;
      max_z_o       <= max_z_q;
      mean_step_x_o <= mean_x_q;
      mean_step_y_o <= mean_now;
    end
  end

endmodule

// File: rtl/core/point_grid_statistics_core.sv
`timescale 1ns / 1ps

// Channel  | Handshake                | Payload
// ---------+--------------------------+---------------------------------------------
// input    | in_valid_i / in_stall_o  | point_valid, coord_x/y/z, last_point
// result   | out_valid_o / out_stall_i| valid_count, min/max x/y/z, mean_step_x/y
// config   | cfg_we_i                 | cfg_wdata_i (grid_width)
//
// A point gets a line-buffer read, then the update and write-back; the next point
// is not taken before that. A final point adds two passes of the shared 53-step
// restoring divider, plus any wait for the previous result transfer; new points
// are taken again while the result waits. A width write stalls the input while
// the line-buffer column is recomputed with the same divider. The line buffer
// needs no clearing pass after reset.
module point_grid_statistics_core #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_POINTS = 1048576
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                point_valid_i,
  input  logic signed [pgs_pkg::COORD_W-1:0]  coord_x_i,
  input  logic signed [pgs_pkg::COORD_W-1:0]  coord_y_i,
  input  logic signed [pgs_pkg::COORD_W-1:0]  coord_z_i,
  input  logic                                last_point_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [pgs_pkg::CNT_OUT_W-1:0]       valid_count_o,
  output logic signed [pgs_pkg::COORD_W-1:0]  min_x_o,
  output logic signed [pgs_pkg::COORD_W-1:0]  max_x_o,
  output logic signed [pgs_pkg::COORD_W-1:0]  min_y_o,
  output logic signed [pgs_pkg::COORD_W-1:0]  max_y_o,
  output logic signed [pgs_pkg::COORD_W-1:0]  min_z_o,
  output logic signed [pgs_pkg::COORD_W-1:0]  max_z_o,
  output logic [pgs_pkg::COORD_W-1:0]         mean_step_x_o,
  output logic [pgs_pkg::COORD_W-1:0]         mean_step_y_o,
  input  logic                                cfg_we_i,
  input  logic [pgs_pkg::GW_W-1:0]            cfg_wdata_i
);

  pgs_pkg::pgs_cmd_t    cmd;
  pgs_pkg::pgs_status_t status;

  // Sequence each transfer and the end-of-frame divisions
  pgs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cfg_we_i    (cfg_we_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Accumulate statistics, line buffer and divider
  pgs_dpath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_POINTS (MAX_POINTS)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .point_valid_i (point_valid_i),
    .coord_x_i     (coord_x_i),
    .coord_y_i     (coord_y_i),
    .coord_z_i     (coord_z_i),
    .last_point_i  (last_point_i),
    .valid_count_o (valid_count_o),
    .min_x_o       (min_x_o),
    .max_x_o       (max_x_o),
    .min_y_o       (min_y_o),
    .max_y_o       (max_y_o),
    .min_z_o       (min_z_o),
    .max_z_o       (max_z_o),
    .mean_step_x_o (mean_step_x_o),
    .mean_step_y_o (mean_step_y_o)
  );

endmodule

// File: rtl/core/pgs_checker.sv
`timescale 1ns / 1ps

module pgs_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_stall_o,
  input logic                               out_valid_o,
  input logic                               out_stall_i,
  input logic                               cfg_we_i,
  input logic [pgs_pkg::CNT_OUT_W-1:0]      valid_count_o,
  input logic [pgs_pkg::COORD_W-1:0]        min_x_o,
  input logic [pgs_pkg::COORD_W-1:0]        max_x_o,
  input logic [pgs_pkg::COORD_W-1:0]        mean_step_x_o,
  input logic [pgs_pkg::COORD_W-1:0]        mean_step_y_o
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(valid_count_o) &&
      $stable(min_x_o) && $stable(max_x_o) && $stable(mean_step_x_o) &&
      $stable(mean_step_y_o))
    else $error("result changed while stalled");

  // Input stays blocked while a taken point is updated
  a_in_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken in the update cycle");

  // A width write blocks input while the column is recomputed
  a_cfg_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> in_stall_o)
    else $error("input open right after a width write");

  // A result appears only out of a busy, non-accepting cycle
  a_out_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result raised while input was open");

  // Results are far apart: none directly after a transfer
  a_out_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i |=> !out_valid_o)
    else $error("back-to-back results");

endmodule

bind point_grid_statistics_core pgs_checker u_pgs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .cfg_we_i      (cfg_we_i),
  .valid_count_o (valid_count_o),
  .min_x_o       (min_x_o),
  .max_x_o       (max_x_o),
  .mean_step_x_o (mean_step_x_o),
  .mean_step_y_o (mean_step_y_o)
);

// File: dv/tb.sv
`timescale 1ns / 1ps

module tb;
  import pgs_pkg::*;

  localparam int unsigned LINE_DEPTH = 1024;
  localparam int unsigned POINT_CAP  = 1048576;
  localparam logic [SUM_W-1:0] SUM_CAP = {SUM_W{1'b1}};

  typedef struct packed {
    logic                      valid;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic                      last;
  } grid_point_t;

  typedef struct packed {
    logic [CNT_OUT_W-1:0]      count;
    logic signed [COORD_W-1:0] min_x;
    logic signed [COORD_W-1:0] max_x;
    logic signed [COORD_W-1:0] min_y;
    logic signed [COORD_W-1:0] max_y;
    logic signed [COORD_W-1:0] min_z;
    logic signed [COORD_W-1:0] max_z;
    logic [COORD_W-1:0]        mean_x;
    logic [COORD_W-1:0]        mean_y;
  } grid_summary_t;

  // Running bounding box and step averages of one grid, plus the summaries still owed
  class frame_stats_tracker;
    logic [GW_W-1:0]           grid_width;
    logic signed [COORD_W-1:0] lo [3];
    logic signed [COORD_W-1:0] hi [3];
    int unsigned               n_valid;
    int unsigned               n_seen;
    int unsigned               n_step_x;
    int unsigned               n_step_y;
    logic [SUM_W-1:0]          sum_x;
    logic [SUM_W-1:0]          sum_y;
    bit                        left_ok;
    logic signed [COORD_W-1:0] left_x;
    bit                        above_ok [LINE_DEPTH];
    logic signed [COORD_W-1:0] above_y [LINE_DEPTH];
    grid_summary_t             due_summaries [$];
    int unsigned               mismatches;
    int unsigned               summaries_seen;

    function new();
      grid_width = GW_RESET;
      mismatches = 0;
      summaries_seen = 0;
      restart();
    endfunction

    function void restart();
      for (int a = 0; a < 3; a++) begin
        lo[a] = POS_MOST;
        hi[a] = NEG_MOST;
      end
      n_valid = 0;
      n_seen = 0;
      n_step_x = 0;
      n_step_y = 0;
      sum_x = '0;
      sum_y = '0;
      left_ok = 0;
      left_x = '0;
    endfunction

    function void set_width(logic [GW_W-1:0] w);
      grid_width = w;
    endfunction

    function logic [COORD_W-1:0] abs_step(logic signed [COORD_W-1:0] a,
                                          logic signed [COORD_W-1:0] b);
      longint d;
      d = longint'(a) - longint'(b);
      if (d < 0) d = -d;
      return d[COORD_W-1:0];
    endfunction

    function logic [SUM_W-1:0] sat_sum(logic [SUM_W-1:0] s, logic [COORD_W-1:0] d);
      logic [SUM_W:0] r;
      r = {1'b0, s} + d;
      return (r > SUM_CAP) ? SUM_CAP : r[SUM_W-1:0];
    endfunction

    function int unsigned sat_inc(int unsigned c);
      return (c >= POINT_CAP) ? POINT_CAP : c + 1;
    endfunction

    function logic [COORD_W-1:0] mean_step(logic [SUM_W-1:0] s, int unsigned n);
      longint unsigned q;
      if (n == 0) return '0;
      q = 64'(s) / 64'(n);
      return (q > 64'hFFFF_FFFF) ? '1 : q[COORD_W-1:0];
    endfunction

    // Fold one accepted point into the grid; queue a summary on the last point
    function void take_point(grid_point_t p);
      int unsigned               w;
      int unsigned               col;
      logic signed [COORD_W-1:0] c [3];
      grid_summary_t             s;
      c[0] = p.x;
      c[1] = p.y;
      c[2] = p.z;
      w = (grid_width == 0) ? 1 : ((grid_width > LINE_DEPTH) ? LINE_DEPTH : grid_width);
      col = n_seen % w;
      if (p.valid) begin
        n_valid = sat_inc(n_valid);
        for (int a = 0; a < 3; a++) begin
          if (c[a] < lo[a]) lo[a] = c[a];
          if (c[a] > hi[a]) hi[a] = c[a];
        end
        if (left_ok) begin
          sum_x = sat_sum(sum_x, abs_step(p.x, left_x));
          n_step_x = sat_inc(n_step_x);
        end
        if (n_seen >= w && above_ok[col]) begin
          sum_y = sat_sum(sum_y, abs_step(p.y, above_y[col]));
          n_step_y = sat_inc(n_step_y);
        end
      end
      above_ok[col] = p.valid;
      above_y[col] = p.y;
      left_ok = p.valid;
      left_x = p.x;
      n_seen = sat_inc(n_seen);
      if (p.last) begin
        s.count  = CNT_OUT_W'(n_valid);
        s.min_x  = lo[0];
        s.max_x  = hi[0];
        s.min_y  = lo[1];
        s.max_y  = hi[1];
        s.min_z  = lo[2];
        s.max_z  = hi[2];
        s.mean_x = mean_step(sum_x, n_step_x);
        s.mean_y = mean_step(sum_y, n_step_y);
        due_summaries.push_back(s);
        restart();
      end
    endfunction

    function void check_field(string name, logic [COORD_W-1:0] want, logic [COORD_W-1:0] got);
      if (want !== got) begin
        mismatches++;
        $display("t=%0t %s mismatch: expected %h, actual %h", $time, name, want, got);
      end
    endfunction

    // Compare a transferred summary with the oldest one owed
    function void match_summary(grid_summary_t got);
      grid_summary_t want;
      summaries_seen++;
      if (due_summaries.size() == 0) begin
        mismatches++;
        $display("t=%0t unexpected summary: expected none, actual count %0d",
                 $time, got.count);
        return;
      end
      want = due_summaries.pop_front();
      check_field("valid_count", 32'(want.count), 32'(got.count));
      check_field("min_x", want.min_x, got.min_x);
      check_field("max_x", want.max_x, got.max_x);
      check_field("min_y", want.min_y, got.min_y);
      check_field("max_y", want.max_y, got.max_y);
      check_field("min_z", want.min_z, got.min_z);
      check_field("max_z", want.max_z, got.max_z);
      check_field("mean_step_x", want.mean_x, got.mean_x);
      check_field("mean_step_y", want.mean_y, got.mean_y);
    endfunction
  endclass

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_stall;
  logic                      pt_valid;
  logic signed [COORD_W-1:0] pt_x;
  logic signed [COORD_W-1:0] pt_y;
  logic signed [COORD_W-1:0] pt_z;
  logic                      pt_last;
  logic                      res_valid;
  logic                      res_stall;
  logic [CNT_OUT_W-1:0]      r_count;
  logic signed [COORD_W-1:0] r_min_x;
  logic signed [COORD_W-1:0] r_max_x;
  logic signed [COORD_W-1:0] r_min_y;
  logic signed [COORD_W-1:0] r_max_y;
  logic signed [COORD_W-1:0] r_min_z;
  logic signed [COORD_W-1:0] r_max_z;
  logic [COORD_W-1:0]        r_mean_x;
  logic [COORD_W-1:0]        r_mean_y;
  logic                      cfg_we;
  logic [GW_W-1:0]           cfg_wdata;

  frame_stats_tracker stats = new();

  bit          steady_pace;
  bit          hold_off_req;
  int unsigned burst_left;
  int unsigned sent_points;
  int unsigned widths_used;
  int unsigned hold_count;

  point_grid_statistics_core dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .point_valid_i (pt_valid),
    .coord_x_i     (pt_x),
    .coord_y_i     (pt_y),
    .coord_z_i     (pt_z),
    .last_point_i  (pt_last),
    .out_valid_o   (res_valid),
    .out_stall_i   (res_stall),
    .valid_count_o (r_count),
    .min_x_o       (r_min_x),
    .max_x_o       (r_max_x),
    .min_y_o       (r_min_y),
    .max_y_o       (r_max_y),
    .min_z_o       (r_min_z),
    .max_z_o       (r_max_z),
    .mean_step_x_o (r_mean_x),
    .mean_step_y_o (r_mean_y),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata)
  );

  // Free-running clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Give up after a generous fixed time
  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Check every summary transfer
  always @(posedge clk) begin
    if (rst_n && res_valid && !res_stall) begin
      stats.match_summary({r_count, r_min_x, r_max_x, r_min_y, r_max_y, r_min_z, r_max_z,
                           r_mean_x, r_mean_y});
    end
  end

  // Stall the result side: free runs, choppy stretches, and one long hold-off on request
  initial begin : result_pacing
    res_stall = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        res_stall <= 1'b1;
        repeat (600) @(posedge clk);
        hold_off_req = 0;
        hold_count++;
      end else if ($urandom_range(0, 3) == 0) begin
        res_stall <= 1'b0;
        repeat ($urandom_range(20, 120)) @(posedge clk);
      end else begin
        res_stall <= 1'($urandom_range(0, 1));
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  end

  function automatic grid_point_t pt(bit v, logic signed [COORD_W-1:0] x,
                                     logic signed [COORD_W-1:0] y,
                                     logic signed [COORD_W-1:0] z, bit last);
    grid_point_t p;
    p.valid = v;
    p.x = x;
    p.y = y;
    p.z = z;
    p.last = last;
    return p;
  endfunction

  // Mostly small Q16.16 values so boxes stay tight, with full-range and extreme values mixed in
  function automatic logic signed [COORD_W-1:0] pick_coord();
    int unsigned r;
    r = $urandom_range(0, 15);
    if (r < 2) begin
      case ($urandom_range(0, 3))
        0:       return POS_MOST;
        1:       return NEG_MOST;
        2:       return '0;
        default: return '1;
      endcase
    end
    if (r < 7) return $urandom;
    return COORD_W'(int'($urandom_range(0, 262143)) - 131072);
  endfunction

  function automatic int unsigned pick_density();
    int unsigned r;
    r = $urandom_range(0, 7);
    if (r == 0) return 0;
    if (r < 3) return 40;
    if (r < 6) return 85;
    return 100;
  endfunction

  // Insert a random gap between bursts unless pacing is steady
  task automatic pace();
    int unsigned gap;
    if (steady_pace) return;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(1, 12);
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Offer one point and hold it until the transfer
  task automatic send_point(grid_point_t p);
    pace();
    in_valid <= 1'b1;
    pt_valid <= p.valid;
    pt_x     <= p.x;
    pt_y     <= p.y;
    pt_z     <= p.z;
    pt_last  <= p.last;
    do @(posedge clk); while (in_stall);
    stats.take_point(p);
    sent_points++;
  endtask

  task automatic send_grid(int unsigned len, int unsigned density);
    grid_point_t p;
    for (int unsigned i = 0; i < len; i++) begin
      p.valid = ($urandom_range(0, 99) < density);
      p.x = pick_coord();
      p.y = pick_coord();
      p.z = pick_coord();
      p.last = (i == len - 1);
      send_point(p);
    end
  endtask

  // Change the width only once the block has drained and finished its division
  task automatic write_width(logic [GW_W-1:0] w);
    in_valid <= 1'b0;
    while (stats.due_summaries.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_we <= 1'b0;
    stats.set_width(w);
    widths_used++;
  endtask

  initial begin : stimulus
    int unsigned w;
    int unsigned eff;
    int unsigned start_count;
    in_valid  = 1'b0;
    pt_valid  = 1'b0;
    pt_x      = '0;
    pt_y      = '0;
    pt_z      = '0;
    pt_last   = 1'b0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    rst_n     = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset width: an empty grid, then a lone point with no pairs
    steady_pace = 1;
    send_point(pt(0, 5, 6, 7, 1));
    send_point(pt(1, POS_MOST, NEG_MOST, 0, 1));
    // Full-scale x step, a hole that breaks the chain, z extremes
    send_point(pt(1, POS_MOST, 0, 1, 0));
    send_point(pt(1, NEG_MOST, 0, -1, 0));
    send_point(pt(0, 0, 0, 0, 0));
    send_point(pt(1, 0, 0, POS_MOST, 0));
    send_point(pt(1, 32'sh0001_8000, -5, NEG_MOST, 1));

    // Width zero acts as one: each point sits under the one before
    write_width(0);
    send_point(pt(1, 0, POS_MOST, 0, 0));
    send_point(pt(1, 0, NEG_MOST, 0, 0));
    send_point(pt(1, 0, POS_MOST, 0, 0));
    send_point(pt(1, 0, 0, 0, 1));

    // Width three: column zero of row two has a neighbor above, row wrap feeds the x step
    write_width(3);
    for (int i = 0; i < 8; i++)
      send_point(pt(i != 4, i * 70000 - 200000, (i % 3) * 9000 - i, i, i == 7));

    // Back-to-back grids: nothing carries over a last point
    write_width(2);
    send_point(pt(1, 100, 100, 100, 1));
    send_point(pt(1, 300, 300, 300, 1));
    send_point(pt(1, 50, 60, 70, 0));
    send_point(pt(1, 51, 61, 71, 1));

    // Tiny grids against a long result hold-off, so the input backs up
    steady_pace = 0;
    write_width(4);
    hold_off_req = 1;
    for (int k = 0; k < 30; k++) send_grid($urandom_range(1, 3), pick_density());

    // Random phases at small widths, several grids each
    start_count = sent_points;
    while (sent_points - start_count < 450) begin
      w = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
      write_width(GW_W'(w));
      eff = (w == 0) ? 1 : w;
      steady_pace = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(2, 5)) send_grid($urandom_range(1, 3 * eff + 2), pick_density());
    end

    // Widest rows: exact limit, then an all-ones width that clamps to it
    steady_pace = 0;
    write_width(11'd1024);
    send_grid(24, 85);
    write_width('1);
    send_grid(24, 90);

    // Drain and let the block settle
    in_valid <= 1'b0;
    while (stats.due_summaries.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("Sent %0d points, checked %0d grid summaries over %0d width settings.",
             sent_points, stats.summaries_seen, widths_used);
    $display("Long result hold-offs with the input backed up: %0d.", hold_count);
    if (stats.mismatches == 0 && stats.due_summaries.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
